[hw/rtl/cubic_bspline_curve_tessellator_defines.svh]
// ----------------------------------------------------------------------------
// Tessellator assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_CURVE_TESSELLATOR_DEFINES_SVH
`define CUBIC_BSPLINE_CURVE_TESSELLATOR_DEFINES_SVH

// same-cycle implication
`define CBT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CBT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cbt_pkg.sv]
// ----------------------------------------------------------------------------
// Tessellator package
// Item types, lane control bundle and fixed constants.
// ----------------------------------------------------------------------------
package cbt_pkg;

   localparam int CoordWidth = 32;
   localparam int CfgWidth   = 7;
   localparam int NumTerms   = 4;
   localparam int NumAxes    = 3;
   localparam logic [CfgWidth-1:0] SegReset = 7'd8;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      logic      curve_start;
   } req_item_type;

   typedef struct packed {
      coord_type curve_x;
      coord_type curve_y;
      coord_type curve_z;
      logic      last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic       load;
      logic       mac_first;
      logic       mac_en;
      logic [1:0] mac_sel;
      logic       div_load;
      logic       div_step;
   } lane_ctl_type;

endpackage

[hw/rtl/cbt_weights.sv]
// ----------------------------------------------------------------------------
// Basis weight unit
// Three-stage pipe that forms the four span weights and the divisor for one
// curve point; i and m must hold steady for three cycles.
// ----------------------------------------------------------------------------
module cbt_weights #(
   parameter int MW = 7,
   parameter int WW = 24
) (
   input  logic                             clock,
   input  logic [MW-1:0]                    m_in,
   input  logic [MW-1:0]                    i_in,
   input  logic                             start_mode,
   output logic [cbt_pkg::NumTerms-1:0][WW-1:0] w_out,
   output logic [WW-1:0]                    d_out
);
   import cbt_pkg::*;

   localparam int SW = 3*MW + 6;

   logic [MW-1:0]   u;
   logic [2*MW-1:0] i2_ff, u2_ff, m2_ff;
   logic [3*MW-1:0] i3_ff, u3_ff, mi2_ff, mu2_ff, m3_ff;
   logic signed [SW-1:0] si3, su3, smi2, smu2, sm3, w1_s, w2_s;
   logic [NumTerms-1:0][WW-1:0] w_ff, w_in;
   logic [WW-1:0] d_ff, d_in;

   assign u = m_in - i_in;

   // squares and cubes
   always_ff @(posedge clock) begin
      i2_ff  <= i_in * i_in;
      u2_ff  <= u * u;
      m2_ff  <= m_in * m_in;
      i3_ff  <= (3*MW)'(i2_ff * i_in);
      u3_ff  <= (3*MW)'(u2_ff * u);
      mi2_ff <= (3*MW)'(i2_ff * m_in);
      mu2_ff <= (3*MW)'(u2_ff * m_in);
      m3_ff  <= (3*MW)'(m2_ff * m_in);
      w_ff   <= w_in;
      d_ff   <= d_in;
   end

   // 3*(n^3 - 2*m*n^2) + 4*m^3
   always_comb begin
      si3  = signed'(SW'(i3_ff));
      su3  = signed'(SW'(u3_ff));
      smi2 = signed'(SW'(mi2_ff));
      smu2 = signed'(SW'(mu2_ff));
      sm3  = signed'(SW'(m3_ff));
      w1_s = (si3 <<< 1) + si3 - ((smi2 <<< 2) + (smi2 <<< 1)) + (sm3 <<< 2);
      w2_s = (su3 <<< 1) + su3 - ((smu2 <<< 2) + (smu2 <<< 1)) + (sm3 <<< 2);
      if (start_mode) begin
         w_in[0] = WW'(1);
         w_in[1] = WW'(4);
         w_in[2] = WW'(1);
         w_in[3] = '0;
         d_in    = WW'(6);
      end else begin
         w_in[0] = WW'(u3_ff);
         w_in[1] = w1_s[WW-1:0];
         w_in[2] = w2_s[WW-1:0];
         w_in[3] = WW'(i3_ff);
         d_in    = WW'({m3_ff, 2'b00}) + WW'({m3_ff, 1'b0});
      end
   end

   assign w_out = w_ff;
   assign d_out = d_ff;

endmodule

[hw/rtl/cbt_lane.sv]
// ----------------------------------------------------------------------------
// Coordinate lane
// Holds four coordinates of one axis, accumulates the weighted sum one term
// a cycle, then divides by the span divisor one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cbt_lane #(
   parameter int WW = 24,
   parameter int AW = 59
) (
   input  logic                                     clock,
   input  cbt_pkg::lane_ctl_type                    ctl,
   input  logic [cbt_pkg::NumTerms-1:0][cbt_pkg::CoordWidth-1:0] c_in,
   input  logic [cbt_pkg::NumTerms-1:0][WW-1:0]     w_in,
   input  logic [WW-1:0]                            d_in,
   output cbt_pkg::coord_type                       q_out
);
   import cbt_pkg::*;

   localparam int PW = CoordWidth + WW + 1;

   logic [NumTerms-1:0][CoordWidth-1:0] c_ff;
   logic signed [PW-1:0] prod;
   logic signed [AW-1:0] prod_ext, acc_ff, acc_in;
   logic [AW-1:0] num_ff, num_in;
   logic [WW-1:0] rem_ff, rem_in;
   logic [WW:0]   shift_val, diff;
   logic          neg_ff, neg_in;

   // weighted sum, one term per cycle
   assign prod     = signed'(c_ff[ctl.mac_sel]) * signed'({1'b0, w_in[ctl.mac_sel]});
   assign prod_ext = {{(AW-PW){prod[PW-1]}}, prod};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.mac_en) begin
         acc_in = ctl.mac_first ? prod_ext : acc_ff + prod_ext;
      end
   end

   // restoring divide on the magnitude
   always_comb begin
      shift_val = {rem_ff, num_ff[AW-1]};
      diff      = shift_val - {1'b0, d_in};
      num_in    = num_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      if (ctl.div_load) begin
         neg_in = acc_ff[AW-1];
         num_in = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
         rem_in = '0;
      end else if (ctl.div_step) begin
         if (shift_val >= {1'b0, d_in}) begin
            rem_in = diff[WW-1:0];
            num_in = {num_ff[AW-2:0], 1'b1};
         end else begin
            rem_in = shift_val[WW-1:0];
            num_in = {num_ff[AW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         c_ff <= c_in;
      end
      acc_ff <= acc_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // truncation toward zero: negate the magnitude quotient
   assign q_out = neg_ff ? coord_type'(-num_ff[CoordWidth-1:0])
                         : coord_type'(num_ff[CoordWidth-1:0]);

endmodule

[hw/rtl/cubic_bspline_curve_tessellator.sv]
// ----------------------------------------------------------------------------
// Cubic B-spline curve tessellator
// Takes control points and emits uniform cubic B-spline curve points.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_stall  | req_item  (point, curve_start)
//  rsp_     | out       | rsp_valid/rsp_stall  | rsp_item  (curve point, last)
//  csr_     | in        | csr_write_enable     | csr_write_data (segments)
//
//  Each curve point passes in order through the weight pipe, the lane
//  multiply-accumulate and the bit-serial divider, then loads the output
//  register. An item with no result leaves the sequencer idle.
//  Three lanes (x, y, z) run in lockstep. Reset is synchronous; history clears.
//  A stalled output holds the sequencer in its output step.
// ----------------------------------------------------------------------------
`include "cubic_bspline_curve_tessellator_defines.svh"

module cubic_bspline_curve_tessellator #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  cbt_pkg::req_item_type       req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cbt_pkg::rsp_item_type       rsp_item,
   input  logic                        csr_write_enable,
   input  logic [cbt_pkg::CfgWidth-1:0] csr_write_data
);
   import cbt_pkg::*;

   localparam int MW   = $clog2(MAX_SEGMENTS + 1);
   localparam int WW   = 3*MW + 3;
   localparam int AW   = CoordWidth + WW + 3;
   localparam int CW   = (MW > CfgWidth) ? MW : CfgWidth;
   localparam int CntW = $clog2(AW + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_WGT  = 5'b00010,
      S_MAC  = 5'b00100,
      S_DIV  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CfgWidth-1:0] seg_ff, seg_in;
   logic [CW-1:0]       seg_ext;
   logic [MW-1:0]       m_now, m_ff, m_in, i_ff, i_in;
   logic                mode_ff, mode_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [1:0]          seen_ff, seen_in, seen_eff;
   logic [NumAxes-1:0][2:0][CoordWidth-1:0] hist_ff, hist_in, hist_eff;
   logic [NumAxes-1:0][CoordWidth-1:0]      pnt;
   logic [NumAxes-1:0][NumTerms-1:0][CoordWidth-1:0] lane_c;
   logic [NumTerms-1:0][WW-1:0] w;
   logic [WW-1:0]       d;
   coord_type           q [NumAxes];
   logic                accept, produce, start_pt, out_free, last_pt;
   lane_ctl_type        ctl;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_pt  = mode_ff || (i_ff == m_ff);

   // segment count clamp
   always_comb begin
      seg_ext = CW'(seg_ff);
      if (seg_ext == '0) begin
         m_now = MW'(1);
      end else if (seg_ext > CW'(MAX_SEGMENTS)) begin
         m_now = MW'(MAX_SEGMENTS);
      end else begin
         m_now = MW'(seg_ext);
      end
   end

   assign seg_in = csr_write_enable ? csr_write_data : seg_ff;

   // history and lane operands
   assign pnt[0] = req_item.point_x;
   assign pnt[1] = req_item.point_y;
   assign pnt[2] = req_item.point_z;

   always_comb begin
      seen_eff = req_item.curve_start ? 2'd0 : seen_ff;
      hist_eff = req_item.curve_start ? '0 : hist_ff;
      produce  = (seen_eff == 2'd3) || (seen_eff == 2'd2);
      start_pt = (seen_eff != 2'd3);
      for (int a = 0; a < NumAxes; a++) begin
         if (seen_eff == 2'd3) begin
            lane_c[a] = {pnt[a], hist_eff[a][2], hist_eff[a][1], hist_eff[a][0]};
         end else begin
            lane_c[a] = {CoordWidth'(0), pnt[a], hist_eff[a][2], hist_eff[a][1]};
         end
      end
      hist_in = hist_ff;
      seen_in = seen_ff;
      if (accept) begin
         for (int a = 0; a < NumAxes; a++) begin
            hist_in[a] = {pnt[a], hist_eff[a][2], hist_eff[a][1]};
         end
         seen_in = (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      m_in         = m_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && produce) begin
               state_in = S_WGT;
               cnt_in   = '0;
               i_in     = MW'(1);
               m_in     = m_now;
               mode_in  = start_pt;
            end
         end
         S_WGT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(2)) begin
               state_in = S_MAC;
               cnt_in   = '0;
            end
         end
         S_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(NumTerms - 1)) begin
               state_in = S_DIV;
               cnt_in   = '0;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(AW)) begin
               state_in = S_OUT;
               cnt_in   = '0;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{curve_x: q[0], curve_y: q[1], curve_z: q[2],
                                last_of_run: last_pt};
               if (last_pt) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_WGT;
                  i_in     = i_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seg_ff       <= SegReset;
         seen_ff      <= 2'd0;
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         seen_ff      <= seen_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      i_ff        <= i_in;
      m_ff        <= m_in;
      mode_ff     <= mode_in;
      rsp_item_ff <= rsp_item_in;
   end

   // lane control
   always_comb begin
      ctl.load      = accept && produce;
      ctl.mac_en    = (state_ff == S_MAC);
      ctl.mac_first = (state_ff == S_MAC) && (cnt_ff == '0);
      ctl.mac_sel   = cnt_ff[1:0];
      ctl.div_load  = (state_ff == S_DIV) && (cnt_ff == '0);
      ctl.div_step  = (state_ff == S_DIV) && (cnt_ff != '0);
   end

   cbt_weights #(.MW(MW), .WW(WW)) u_weights (
      .clock      (clock),
      .m_in       (m_ff),
      .i_in       (i_ff),
      .start_mode (mode_ff),
      .w_out      (w),
      .d_out      (d)
   );

   // one lane per axis
   for (genvar a = 0; a < NumAxes; a++) begin : g_lane
      cbt_lane #(.WW(WW), .AW(AW)) u_lane (
         .clock (clock),
         .ctl   (ctl),
         .c_in  (lane_c[a]),
         .w_in  (w),
         .d_in  (d),
         .q_out (q[a])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `CBT_ASSERT_NEXT(a_out_load, (state_ff == S_OUT) && out_free, rsp_valid_ff, "output not loaded")
   `CBT_ASSERT_IMPL(a_div_count, state_ff == S_DIV, cnt_ff <= CntW'(AW), "divider overran")
   `CBT_ASSERT_IMPL(a_index_range, state_ff == S_OUT, (i_ff != '0) && (i_ff <= m_ff), "bad index")

endmodule

[tb/sv/cubic_bspline_curve_tessellator_checker.sv]
// ----------------------------------------------------------------------------
// Tessellator checker
// Watches the point, curve point and segment register ports, predicts every
// curve point from its own copy of the history and compares in order.
// ----------------------------------------------------------------------------
module cubic_bspline_curve_tessellator_checker
   import cbt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  req_item_type        req_item,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rsp_item_type        rsp_item,
   input  logic                csr_write_enable,
   input  logic [CfgWidth-1:0] csr_write_data,
   output int                  fail_count,
   output int                  pending_points,
   output int                  checked_points
);

   localparam longint MaxSegments = 64;

   rsp_item_type        expected_points[$];
   longint              history[NumAxes][3];
   int                  held_points;
   logic [CfgWidth-1:0] segments;

   // weighted sum over divisor, exact, truncated toward zero
   function automatic longint weighted_div(longint c[4], longint w[4], longint d);
      longint hi_acc, lo_acc, lo, hi, qa, ra, t, q;
      hi_acc = 0;
      lo_acc = 0;
      for (int k = 0; k < 4; k++) begin
         lo = c[k] & 64'hFFFF;
         hi = (c[k] - lo) / 65536;
         hi_acc += w[k] * hi;
         lo_acc += w[k] * lo;
      end
      qa = hi_acc / d;
      ra = hi_acc % d;
      if (ra < 0) begin
         ra += d;
         qa -= 1;
      end
      t = ra * 65536 + lo_acc;
      q = qa * 65536 + t / d;
      if (q < 0 && (t % d) != 0) q += 1;
      return q;
   endfunction

   // predict the curve points caused by one control point
   task automatic predict_points(input req_item_type it);
      longint       pt[NumAxes];
      longint       c[4], w[4];
      longint       m, m3, u;
      longint       r[NumAxes];
      rsp_item_type exp_pt;
      pt[0] = longint'(it.point_x);
      pt[1] = longint'(it.point_y);
      pt[2] = longint'(it.point_z);
      if (it.curve_start) begin
         foreach (history[a, k]) history[a][k] = 0;
         held_points = 0;
      end
      if (held_points >= 3) begin
         m = longint'(segments);
         if (m < 1) m = 1;
         if (m > MaxSegments) m = MaxSegments;
         m3 = m * m * m;
         for (longint i = 1; i <= m; i++) begin
            u = m - i;
            w[0] = u * u * u;
            w[1] = 3 * (i * i * i - 2 * m * i * i) + 4 * m3;
            w[2] = 3 * (u * u * u - 2 * m * u * u) + 4 * m3;
            w[3] = i * i * i;
            for (int a = 0; a < NumAxes; a++) begin
               c[0] = history[a][0];
               c[1] = history[a][1];
               c[2] = history[a][2];
               c[3] = pt[a];
               r[a] = weighted_div(c, w, 6 * m3);
            end
            exp_pt.curve_x     = coord_type'(r[0]);
            exp_pt.curve_y     = coord_type'(r[1]);
            exp_pt.curve_z     = coord_type'(r[2]);
            exp_pt.last_of_run = (i == m);
            expected_points.push_back(exp_pt);
         end
         for (int a = 0; a < NumAxes; a++) begin
            history[a][0] = history[a][1];
            history[a][1] = history[a][2];
            history[a][2] = pt[a];
         end
      end else begin
         for (int a = 0; a < NumAxes; a++) begin
            history[a][0] = history[a][1];
            history[a][1] = history[a][2];
            history[a][2] = pt[a];
         end
         held_points++;
         // third point gives the span start
         if (held_points == 3) begin
            w[0] = 1;
            w[1] = 4;
            w[2] = 1;
            w[3] = 0;
            for (int a = 0; a < NumAxes; a++) begin
               c[0] = history[a][0];
               c[1] = history[a][1];
               c[2] = history[a][2];
               c[3] = 0;
               r[a] = weighted_div(c, w, 6);
            end
            exp_pt.curve_x     = coord_type'(r[0]);
            exp_pt.curve_y     = coord_type'(r[1]);
            exp_pt.curve_z     = coord_type'(r[2]);
            exp_pt.last_of_run = 1'b1;
            expected_points.push_back(exp_pt);
         end
      end
   endtask

   // sample all ports on the clock edge
   always @(posedge clock) begin
      rsp_item_type exp_pt;
      if (reset) begin
         foreach (history[a, k]) history[a][k] = 0;
         held_points = 0;
         segments = SegReset;
         expected_points.delete();
         fail_count = 0;
         checked_points = 0;
      end else begin
         if (csr_write_enable) segments = csr_write_data;
         if (req_valid && !req_stall) predict_points(req_item);
         if (rsp_valid && !rsp_stall) begin
            checked_points++;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected curve point %h", $time, rsp_item);
               fail_count++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_item.curve_x !== exp_pt.curve_x ||
                   rsp_item.curve_y !== exp_pt.curve_y ||
                   rsp_item.curve_z !== exp_pt.curve_z ||
                   rsp_item.last_of_run !== exp_pt.last_of_run) begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h last=%b",
                           $time, exp_pt.curve_x, exp_pt.curve_y, exp_pt.curve_z,
                           exp_pt.last_of_run);
                  $display("%0t:          actual   x=%h y=%h z=%h last=%b",
                           $time, rsp_item.curve_x, rsp_item.curve_y,
                           rsp_item.curve_z, rsp_item.last_of_run);
                  fail_count++;
               end
            end
         end
      end
      pending_points = expected_points.size();
   end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Tessellator testbench
// Drives control point curves under random idling and output stalls across
// several segment settings; the checker predicts and compares curve points.
// ----------------------------------------------------------------------------
module testbench;
   import cbt_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_item_type        req_item = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_item_type        rsp_item;
   logic                csr_write_enable = 1'b0;
   logic [CfgWidth-1:0] csr_write_data = '0;
   int                  fail_count, pending_points, checked_points;
   int                  items_sent = 0;
   int                  settings_used = 1;
   bit                  calm = 1'b0;

   cubic_bspline_curve_tessellator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   cubic_bspline_curve_tessellator_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_points(pending_points),
      .checked_points(checked_points)
   );

   always #5 clock = ~clock;

   // random output stall, none during calm stretches
   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
   end

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 6))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return coord_type'($urandom_range(0, 262143)) - 32'sd131072;
         3: return '0;
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic send_point(input coord_type x, input coord_type y,
                             input coord_type z, input logic start);
      int gap;
      gap = 0;
      while (!calm && $urandom_range(0, 99) < 33) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{point_x: x, point_y: y, point_z: z, curve_start: start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_segments(input logic [CfgWidth-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // curves of random length with some stray start flags
   task automatic send_curves(input int count);
      int left;
      left = 0;
      repeat (count) begin
         if (left == 0) begin
            left = $urandom_range(1, 10);
            send_point(pick_coord(), pick_coord(), pick_coord(), 1'b1);
         end else begin
            send_point(pick_coord(), pick_coord(), pick_coord(),
                       $urandom_range(0, 99) < 8);
         end
         left--;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes at the reset segment count
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
      // start flag on a second point, then on a third
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 1'b1);
      send_point(32'h0002_0000, 32'hFFFE_0000, 32'h0000_FFFF, 1'b1);
      send_point(32'h0003_0000, 32'hFFFD_0000, 32'hFFFF_0001, 1'b0);
      send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFB, 1'b1);
      send_point(32'h0000_0005, 32'hFFFF_FFFD, 32'h0000_0007, 1'b0);
      send_point(32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFF9, 1'b0);
      send_point(32'h0000_0003, 32'hFFFF_FFFE, 32'h0000_0004, 1'b0);

      // one segment, then the largest counts and out-of-range values
      write_segments(7'd1);
      send_curves(40);
      write_segments(7'd64);
      send_curves(8);
      write_segments(7'd0);
      calm = 1'b1;
      send_curves(30);
      calm = 1'b0;
      write_segments(7'd127);
      send_curves(8);
      repeat (7) begin
         write_segments(7'($urandom_range(1, 12)));
         send_curves(40);
      end

      wait_idle();
      repeat (100) @(posedge clock);
      $display("ran %0d control points over %0d segment settings",
               items_sent, settings_used);
      $display("checked %0d curve points", checked_points);
      if (fail_count == 0)
         $display("[cubic_bspline_curve_tessellator] OK");
      else
         $display("[cubic_bspline_curve_tessellator] ERROR");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("[cubic_bspline_curve_tessellator] ERROR");
      $finish;
   end

endmodule
